### sv/mcat_pkg.sv
// Shared types and constants for the multi-channel alarm timer.
package mcat_pkg;

  // Item kinds on the mode input
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SET  = 1'b1;

  // Lamp action codes; every other code turns the lamp off
  localparam logic [1:0] ACT_ON     = 2'd1;
  localparam logic [1:0] ACT_TOGGLE = 2'd2;

  // Kind of a firing
  localparam logic KIND_ONESHOT = 1'b0;
  localparam logic KIND_DAILY   = 1'b1;

  // Deadline scale: seconds per delay unit
  localparam int unsigned DELAY_SCALE = 10;

  // Minute tracker value meaning no minute seen yet
  localparam logic [6:0] NO_MINUTE = 7'd127;

  // Constant division: floor(2^32 / D), quotient estimate is low by at most one
  localparam int unsigned RECIP_W = 28;
  localparam int unsigned PROD_W  = 32 + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_60 = 28'd71582788;
  localparam logic [RECIP_W-1:0] RECIP_24 = 28'd178956970;
  localparam logic [6:0] SEC_PER_MIN   = 7'd60;
  localparam logic [6:0] MIN_PER_HOUR  = 7'd60;
  localparam logic [6:0] HOURS_PER_DAY = 7'd24;

  // Division rounds: seconds to minutes, minutes to hours, hours to hour of day
  typedef enum logic [1:0] {
    DIV_SEC,
    DIV_MIN,
    DIV_HOUR
  } div_round_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       accept;     // latch the input item
    logic       load;       // write the latched set item into the table
    logic       div_mul;    // multiply by the reciprocal
    logic       div_fix;    // correct quotient and remainder
    div_round_t round;      // current division round
    logic       idx_clr;    // restart the channel scan
    logic       rd;         // read the table at the scan index
    logic       eval;       // evaluate the entry read last cycle
    logic       eval_kind;  // one-shot or daily test
    logic       seen_upd;   // record the current minute
    logic       flush;      // send the held result as the final one
  } mcat_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic idx_last;    // scan index is at the last channel
    logic minute_new;  // minute of uptime differs from the last one seen
  } mcat_status_t;

endpackage

### sv/multi_channel_alarm_timer.sv
// Top level of the multi-channel alarm timer: controller plus datapath.
//
// Usage: raise start with an item on the input ports; it is taken at a clock
// edge where busy is low. mode selects a set item (write one channel) or a
// tick item (check all channels against uptime).
// A set item keeps busy high for one cycle while the channel record is written;
// it gives no result.
// A tick splits uptime into minute and hour of day with a reciprocal multiply
// unit (a multiply state and a correction state per division round), scans
// the channel table once for one-shot deadlines (one table read per cycle),
// scans it again for daily alarms when a new minute has begun, then drains its
// last result; the table read port sets the scan length.
// Each firing appears for one cycle with valid high; last marks the final one
// of the tick. A quiet tick gives no result. The receiver cannot stall: every
// result is taken in the cycle it is shown.
// Reset disables all channels, turns the lamp off and forgets the last minute.
module multi_channel_alarm_timer
  import mcat_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [31:0] uptime,
  input  logic [2:0]  channel,
  input  logic        enable,
  input  logic [1:0]  action,
  input  logic [15:0] delay,
  input  logic [4:0]  alarm_hour,
  input  logic [5:0]  alarm_minute,
  output logic        valid,
  output logic [2:0]  fired_channel,
  output logic        fired_kind,
  output logic        lamp_on,
  output logic        last
);

  mcat_cmd_t    cmd;
  mcat_status_t status;
  logic         start_ok;

  // Only offer a transfer to the controller while idle
  assign start_ok = start && !busy;

  mcat_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start_ok),
    .mode   (mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  mcat_dpath #(
    .CHANNELS (CHANNELS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .uptime        (uptime),
    .channel       (channel),
    .enable        (enable),
    .action        (action),
    .delay         (delay),
    .alarm_hour    (alarm_hour),
    .alarm_minute  (alarm_minute),
    .valid         (valid),
    .fired_channel (fired_channel),
    .fired_kind    (fired_kind),
    .lamp_on       (lamp_on),
    .last          (last)
  );

endmodule

### sv/mcat_ctrl.sv
// Controller state machine for the multi-channel alarm timer.
module mcat_ctrl
  import mcat_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         mode,
  input  mcat_status_t status,
  output mcat_cmd_t    cmd,
  output logic         busy
);

  typedef enum logic [2:0] {
    IDLE,
    LOAD,
    DIV_MUL,
    DIV_FIX,
    SCAN_ONE,
    SCAN_DAY,
    FLUSH
  } state_t;

  state_t     state, state_next;
  div_round_t round, round_next;
  logic       rd_active, rd_active_next;
  logic       eval_pend, eval_pend_next;

  // Decode commands and next state
  always_comb begin
    cmd            = '0;
    cmd.round      = round;
    state_next     = state;
    round_next     = round;
    rd_active_next = rd_active;
    eval_pend_next = eval_pend;
    unique case (state)
      IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          round_next = DIV_SEC;
          state_next = (mode == MODE_SET) ? LOAD : DIV_MUL;
        end
      end
      LOAD: begin
        cmd.load   = 1'b1;
        state_next = IDLE;
      end
      DIV_MUL: begin
        cmd.div_mul = 1'b1;
        state_next  = DIV_FIX;
      end
      DIV_FIX: begin
        cmd.div_fix = 1'b1;
        unique case (round)
          DIV_SEC: begin
            round_next = DIV_MIN;
            state_next = DIV_MUL;
          end
          DIV_MIN: begin
            round_next = DIV_HOUR;
            state_next = DIV_MUL;
          end
          default: begin
            cmd.idx_clr    = 1'b1;
            rd_active_next = 1'b1;
            eval_pend_next = 1'b0;
            state_next     = SCAN_ONE;
          end
        endcase
      end
      SCAN_ONE, SCAN_DAY: begin
        cmd.rd         = rd_active;
        cmd.eval       = eval_pend;
        cmd.eval_kind  = (state == SCAN_DAY) ? KIND_DAILY : KIND_ONESHOT;
        rd_active_next = rd_active && !status.idx_last;
        eval_pend_next = rd_active;
        if (!rd_active && eval_pend) begin
          if (state == SCAN_ONE && status.minute_new) begin
            cmd.seen_upd   = 1'b1;
            cmd.idx_clr    = 1'b1;
            rd_active_next = 1'b1;
            eval_pend_next = 1'b0;
            state_next     = SCAN_DAY;
          end else begin
            state_next = FLUSH;
          end
        end
      end
      FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = IDLE;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // Hold state and the busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      round     <= DIV_SEC;
      rd_active <= 1'b0;
      eval_pend <= 1'b0;
      busy      <= 1'b0;
    end else begin
      state     <= state_next;
      round     <= round_next;
      rd_active <= rd_active_next;
      eval_pend <= eval_pend_next;
      busy      <= (state_next != IDLE);
    end
  end

endmodule

### sv/mcat_dpath.sv
// Datapath for the multi-channel alarm timer: channel table, clock split, scan and results.
module mcat_dpath
  import mcat_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  mcat_cmd_t    cmd,
  output mcat_status_t status,
  input  logic [31:0]  uptime,
  input  logic [2:0]   channel,
  input  logic         enable,
  input  logic [1:0]   action,
  input  logic [15:0]  delay,
  input  logic [4:0]   alarm_hour,
  input  logic [5:0]   alarm_minute,
  output logic         valid,
  output logic [2:0]   fired_channel,
  output logic         fired_kind,
  output logic         lamp_on,
  output logic         last
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef struct packed {
    logic [1:0]  action;
    logic        daily;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [31:0] deadline;
  } chan_rec_t;

  // Latched input item
  logic [31:0] up_reg;
  logic [2:0]  set_ch;
  logic        set_en;
  logic [1:0]  set_act;
  logic        set_daily;
  logic [4:0]  set_hour;
  logic [5:0]  set_min;
  logic [19:0] set_dly10;

  // Channel table
  chan_rec_t           mem [CHANNELS];
  logic [CHANNELS-1:0] chan_en;
  logic                set_in_range;
  logic [IDX_W-1:0]    set_idx;

  // Clock split
  logic [31:0]         div_x;
  logic [PROD_W-1:0]   div_prod;
  logic [RECIP_W-1:0]  div_recip;
  logic [6:0]          div_d;
  logic [RECIP_W-1:0]  q_est;
  logic [31:0]         r_est;
  logic                r_over;
  logic [31:0]         q_fix;
  logic [6:0]          r_fix;
  logic [5:0]          cur_min;
  logic [4:0]          cur_hour;
  logic [6:0]          seen_minute;

  // Scan
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] ev_idx;
  chan_rec_t        rd_rec;
  logic             hit;
  logic             lamp_state;
  logic             lamp_new;

  // Held result waiting to learn whether it is the final one
  logic             pend_valid;
  logic [2:0]       pend_ch;
  logic             pend_kind;
  logic             pend_lamp;

  assign set_in_range = (7'(set_ch) < 7'(CHANNELS));
  assign set_idx      = IDX_W'(set_ch);

  // Latch the item on transfer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      up_reg    <= uptime;
      set_ch    <= channel;
      set_en    <= enable;
      set_act   <= action;
      set_daily <= (delay == 16'd0);
      set_hour  <= alarm_hour;
      set_min   <= alarm_minute;
      set_dly10 <= 20'(delay) * 20'(DELAY_SCALE);
    end
  end

  // Write the channel record
  always_ff @(posedge clk) begin
    if (cmd.load && set_in_range) begin
      mem[set_idx] <= '{action:   set_act,
                        daily:    set_daily,
                        hour:     set_hour,
                        minute:   set_min,
                        deadline: up_reg + 32'(set_dly10)};
    end
  end

  // Read the channel record for the scan
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_rec <= mem[rd_idx];
      ev_idx <= rd_idx;
    end
  end

  // Advance the scan index
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.idx_clr) begin
      rd_idx <= '0;
    end else if (cmd.rd) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
  end

  assign status.idx_last   = (rd_idx == IDX_W'(CHANNELS - 1));
  assign status.minute_new = ({1'b0, cur_min} != seen_minute);

  // Select the divisor for this round
  always_comb begin
    unique case (cmd.round)
      DIV_SEC: begin
        div_recip = RECIP_60;
        div_d     = SEC_PER_MIN;
      end
      DIV_MIN: begin
        div_recip = RECIP_60;
        div_d     = MIN_PER_HOUR;
      end
      default: begin
        div_recip = RECIP_24;
        div_d     = HOURS_PER_DAY;
      end
    endcase
  end

  // Correct the quotient estimate by at most one
  assign q_est  = div_prod[PROD_W-1:32];
  assign r_est  = div_x - 32'(q_est) * 32'(div_d);
  assign r_over = (r_est >= 32'(div_d));
  assign q_fix  = 32'(q_est) + 32'(r_over);
  assign r_fix  = r_over ? (r_est[6:0] - div_d) : r_est[6:0];

  // Split uptime into minute and hour of day
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      div_x <= uptime;
    end else if (cmd.div_fix) begin
      div_x <= q_fix;
    end
    if (cmd.div_mul) begin
      div_prod <= PROD_W'(div_x) * PROD_W'(div_recip);
    end
    if (cmd.div_fix) begin
      unique case (cmd.round)
        DIV_SEC:  ;
        DIV_MIN:  cur_min  <= r_fix[5:0];
        default:  cur_hour <= r_fix[4:0];
      endcase
    end
  end

  // Test the entry read last cycle and work out its lamp action
  always_comb begin
    if (cmd.eval_kind == KIND_ONESHOT) begin
      hit = chan_en[ev_idx] && !rd_rec.daily && (up_reg >= rd_rec.deadline);
    end else begin
      hit = chan_en[ev_idx] && rd_rec.daily && (rd_rec.hour == cur_hour) &&
            (rd_rec.minute == cur_min);
    end
    priority if (rd_rec.action == ACT_ON) begin
      lamp_new = 1'b1;
    end else if (rd_rec.action == ACT_TOGGLE) begin
      lamp_new = !lamp_state;
    end else begin
      lamp_new = 1'b0;
    end
  end

  // Hold enables, lamp, minute tracker and the held result, and drive the outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_en     <= '0;
      lamp_state  <= 1'b0;
      seen_minute <= NO_MINUTE;
      pend_valid  <= 1'b0;
      valid       <= 1'b0;
    end else begin
      valid <= pend_valid && ((cmd.eval && hit) || cmd.flush);
      if (cmd.load && set_in_range) begin
        chan_en[set_idx] <= set_en;
      end
      if (cmd.seen_upd) begin
        seen_minute <= {1'b0, cur_min};
      end
      if (cmd.eval && hit) begin
        lamp_state <= lamp_new;
        if (cmd.eval_kind == KIND_ONESHOT) begin
          chan_en[ev_idx] <= 1'b0;
        end
        // Send the previous firing, then hold this one
        if (pend_valid) begin
          fired_channel <= pend_ch;
          fired_kind    <= pend_kind;
          lamp_on       <= pend_lamp;
          last          <= 1'b0;
        end
        pend_valid <= 1'b1;
        pend_ch    <= 3'(ev_idx);
        pend_kind  <= cmd.eval_kind;
        pend_lamp  <= lamp_new;
      end
      if (cmd.flush && pend_valid) begin
        fired_channel <= pend_ch;
        fired_kind    <= pend_kind;
        lamp_on       <= pend_lamp;
        last          <= 1'b1;
        pend_valid    <= 1'b0;
      end
    end
  end

endmodule
